// File: hw/rtl/mmcs_pkg.sv
// Shared definitions for the min/max contrast stretch block.
// Command codes, pixel width and default frame capacity. No dependencies.
package mmcs_pkg;

	localparam int PIX_W = 8;
	localparam int DEF_PIXEL_CAPACITY = 4096;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

endpackage

// File: hw/rtl/mmcs_store.sv
// Frame pixel store: one write port, one registered read port.
// Depends on mmcs_pkg for the pixel width.
module mmcs_store import mmcs_pkg::*; #(
	parameter int DEPTH = DEF_PIXEL_CAPACITY,
	parameter int AW = $clog2(DEF_PIXEL_CAPACITY)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [PIX_W-1:0] rd_data
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/mmcs_div.sv
// Restoring divider: 16-bit dividend by 8-bit divisor, one quotient bit per cycle.
// The caller guarantees the quotient fits in eight bits. Depends on mmcs_pkg.
module mmcs_div import mmcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [2*PIX_W-1:0] dividend,
	input  logic [PIX_W-1:0]   divisor,
	output logic               done,
	output logic [PIX_W-1:0]   quotient
);

	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] shf_q;
	logic [PIX_W-1:0] dsr_q;
	logic [2:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [PIX_W:0]   trial;
	logic             fits;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, shf_q[PIX_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= dividend[2*PIX_W-1:PIX_W];
			shf_q <= dividend[PIX_W-1:0];
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? PIX_W'(trial - {1'b0, dsr_q}) : trial[PIX_W-1:0];
			shf_q <= {shf_q[PIX_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = shf_q;

endmodule

// File: hw/rtl/min_max_contrast_stretch_top.sv
// Min/max contrast stretch top level: command sequencer, pixel store, shared divider.
// Load and clear are taken only in idle and keep busy low. A read with pixels left
// holds busy for the store fetch and, unless the frame is flat, eight divider steps
// and the result write. An empty read registers its result at accept; a flat read ends in fetch.
// Results appear for one cycle with done high; the receiver cannot stall.
// Reset (arst_n low, asynchronous) empties the frame; store contents stay undefined.
module min_max_contrast_stretch_top import mmcs_pkg::*; #(
	parameter int PIXEL_CAPACITY = DEF_PIXEL_CAPACITY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       cmd,
	input  logic [PIX_W-1:0] pixel,
	output logic             done,
	output logic [PIX_W-1:0] value,
	output logic             last,
	output logic             flat,
	output logic             overflow,
	output logic             empty_res
);

	localparam int CW = $clog2(PIXEL_CAPACITY + 1);
	localparam int AW = $clog2(PIXEL_CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_DIV   = 3'b100
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      rd_ptr_q;
	logic [PIX_W-1:0]   min_q;
	logic [PIX_W-1:0]   max_q;
	logic               ovf_seen_q;
	logic               done_q;
	logic               last_pend_q;
	logic [PIX_W-1:0]   value_q;
	logic               last_q;
	logic               flat_q;
	logic               ovf_q;
	logic               empty_q;

	logic               take;
	logic               full;
	logic               none_left;
	logic               wr_en;
	logic               rd_en;
	logic [PIX_W-1:0]   rd_pix;
	logic               flat_now;
	logic [PIX_W-1:0]   num;
	logic [2*PIX_W-1:0] numer;
	logic               div_load;
	logic               div_done;
	logic [PIX_W-1:0]   quot;
	logic               finish;

	assign busy      = state_q != ST_IDLE;
	assign take      = start && !busy;
	assign full      = count_q == CW'(PIXEL_CAPACITY);
	assign none_left = rd_ptr_q >= count_q;
	assign wr_en     = take && cmd == CMD_LOAD && !full;
	assign rd_en     = take && cmd == CMD_READ && !none_left;

	assign flat_now = max_q <= min_q;
	assign num      = (rd_pix > min_q) ? rd_pix - min_q : '0;
	// num * 255 as a shift and subtract
	assign numer    = {num, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, num};
	assign div_load = state_q == ST_FETCH && !flat_now;
	assign finish   = (state_q == ST_FETCH && flat_now) || (state_q == ST_DIV && div_done);

	mmcs_store #(
		.DEPTH (PIXEL_CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (pixel),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (rd_pix)
	);

	mmcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (numer),
		.divisor  (max_q - min_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_ptr_q   <= '0;
			min_q      <= FULL_SCALE;
			max_q      <= '0;
			ovf_seen_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (cmd)
							CMD_LOAD: begin
								if (full) begin
									ovf_seen_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
									if (pixel < min_q) min_q <= pixel;
									if (pixel > max_q) max_q <= pixel;
								end
							end
							CMD_READ: begin
								if (none_left) begin
									done_q <= 1'b1;
								end else begin
									state_q <= ST_FETCH;
								end
							end
							CMD_CLEAR: begin
								count_q    <= '0;
								rd_ptr_q   <= '0;
								min_q      <= FULL_SCALE;
								max_q      <= '0;
								ovf_seen_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_FETCH: begin
					if (!flat_now) state_q <= ST_DIV;
				end
				ST_DIV: begin
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				state_q <= ST_IDLE;
				done_q  <= 1'b1;
				// last pixel read: drop the frame
				if (last_pend_q) begin
					count_q    <= '0;
					rd_ptr_q   <= '0;
					min_q      <= FULL_SCALE;
					max_q      <= '0;
					ovf_seen_q <= 1'b0;
				end else begin
					rd_ptr_q <= rd_ptr_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_pend_q <= (rd_ptr_q + CW'(1)) == count_q;
		end
		if (take && cmd == CMD_READ && none_left) begin
			value_q <= '0;
			last_q  <= 1'b0;
			flat_q  <= 1'b0;
			ovf_q   <= ovf_seen_q;
			empty_q <= 1'b1;
		end else if (finish) begin
			value_q <= flat_now ? '0 : quot;
			last_q  <= last_pend_q;
			flat_q  <= flat_now;
			ovf_q   <= ovf_seen_q;
			empty_q <= 1'b0;
		end
	end

	assign done      = done_q;
	assign value     = value_q;
	assign last      = last_q;
	assign flat      = flat_q;
	assign overflow  = ovf_q;
	assign empty_res = empty_q;

	a_ptr_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		rd_ptr_q <= count_q)
		else $error("read pointer beyond pixel count");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 |-> min_q <= max_q)
		else $error("running minimum above running maximum in a loaded frame");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && flat_q |-> value_q == '0 && !empty_q)
		else $error("flat result with nonzero value");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && empty_q |-> !last_q && !flat_q && value_q == '0)
		else $error("empty result carries pixel data");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && last_q && !empty_q |-> count_q == '0 && rd_ptr_q == '0)
		else $error("frame not cleared after last pixel");

endmodule
